// ===== rtl/hid_keyboard_report_builder_assert.svh =====
// assertion macros shared by the keyboard report builder checker
// depends on a clk and an active-low rst_n in the including scope
`ifndef HID_KEYBOARD_REPORT_BUILDER_ASSERT_SVH
`define HID_KEYBOARD_REPORT_BUILDER_ASSERT_SVH

// same-cycle implication, off during reset
`define HKRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hkrb assertion failed");

// next-cycle implication, off during reset
`define HKRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hkrb assertion failed");

// next-cycle implication, also checked through reset
`define HKRB_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hkrb assertion failed");

`endif

// ===== rtl/hkrb_pkg.sv =====
// shared types, event codes and key tables for the keyboard report builder
// no dependencies
package hkrb_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int OUT_SLOTS = 6;
  localparam int SHOWN_SLOTS = (KEY_SLOTS < OUT_SLOTS) ? KEY_SLOTS : OUT_SLOTS;

  localparam logic [7:0] RAW_BASE   = 8'd136;
  localparam logic [7:0] LEFT_SHIFT = 8'h02;

  typedef enum logic [2:0] {
    OP_PRESS       = 3'd0,
    OP_RELEASE     = 3'd1,
    OP_MEDIA_PRESS = 3'd2,
    OP_MEDIA_REL   = 3'd3,
    OP_RELEASE_ALL = 3'd4,
    OP_LINK_UP     = 3'd5,
    OP_LINK_DOWN   = 3'd6,
    OP_TYPE_CHAR   = 3'd7
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  key_code;
    logic [15:0] media_mask;
  } in_t;

  typedef struct packed {
    logic        report_kind;
    logic [7:0]  modifier_bits;
    logic [7:0]  slot_a;
    logic [7:0]  slot_b;
    logic [7:0]  slot_c;
    logic [7:0]  slot_d;
    logic [7:0]  slot_e;
    logic [7:0]  slot_f;
    logic [15:0] media_bits;
    logic        accepted;
    logic        sent;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic [7:0]                 mods;
    logic [KEY_SLOTS-1:0][7:0]  slots;
  } kbd_t;

  // ascii to usage, top bit adds left shift, zero means unmapped
  localparam logic [7:0] ASCII_USAGE [128] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h2a,8'h2b,8'h28,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h2c,8'h9e,8'hb4,8'ha0,8'ha1,8'ha2,8'ha4,8'h34,
    8'ha6,8'ha7,8'ha5,8'hae,8'h36,8'h2d,8'h37,8'h38,
    8'h27,8'h1e,8'h1f,8'h20,8'h21,8'h22,8'h23,8'h24,
    8'h25,8'h26,8'hb3,8'h33,8'hb6,8'h2e,8'hb7,8'hb8,
    8'h9f,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,
    8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h91,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,
    8'h9b,8'h9c,8'h9d,8'h2f,8'h31,8'h30,8'ha3,8'had,
    8'h35,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,
    8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,8'h10,8'h11,8'h12,
    8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1a,
    8'h1b,8'h1c,8'h1d,8'haf,8'hb1,8'hb0,8'hb5,8'h00
  };

endpackage

// ===== rtl/hid_keyboard_report_builder.sv =====
// hid boot keyboard report builder: event decode, report state, result queue
// depends on hkrb_pkg
// each accepted event's results are written into the result queue and offered from its head
// release all and type char queue a second result behind the first
// throughput: one event per cycle while at most two results are queued
// reset clears modifiers, key slots, media mask, link flag and the queue
module hid_keyboard_report_builder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hkrb_pkg::in_t in_payload,
  output logic          out_valid,
  input  logic          out_stall,
  output hkrb_pkg::out_t out_payload
);

  typedef struct packed {
    logic [7:0] usage;
    logic [7:0] mods;
    logic       ok;
  } map_t;

  typedef struct packed {
    hkrb_pkg::kbd_t kbd;
    logic           ok;
  } kstep_t;

  function automatic map_t map_code(logic [7:0] code);
    map_t       m;
    logic [7:0] t;
    m = '0;
    t = hkrb_pkg::ASCII_USAGE[code[6:0]];
    if (code >= hkrb_pkg::RAW_BASE) begin
      m.usage = code - hkrb_pkg::RAW_BASE;
      m.ok    = 1'b1;
    end else if (code[7]) begin
      m.mods = 8'd1 << code[2:0];
      m.ok   = 1'b1;
    end else if (t != 8'd0) begin
      m.usage = {1'b0, t[6:0]};
      m.mods  = t[7] ? hkrb_pkg::LEFT_SHIFT : 8'd0;
      m.ok    = 1'b1;
    end
    return m;
  endfunction

  function automatic kstep_t key_press(hkrb_pkg::kbd_t k, logic [7:0] code);
    kstep_t s;
    map_t   m;
    logic   held;
    logic   placed;
    s    = '{kbd: k, ok: 1'b0};
    m    = map_code(code);
    held = 1'b0;
    placed = 1'b0;
    if (m.ok) begin
      s.kbd.mods = k.mods | m.mods;
      for (int i = 0; i < hkrb_pkg::KEY_SLOTS; i++) begin
        if (k.slots[i] == m.usage) held = 1'b1;
      end
      if (held) begin
        s.ok = 1'b1;
      end else begin
        for (int i = 0; i < hkrb_pkg::KEY_SLOTS; i++) begin
          if (!placed && k.slots[i] == 8'd0) begin
            s.kbd.slots[i] = m.usage;
            placed = 1'b1;
          end
        end
        s.ok = placed;
      end
    end
    return s;
  endfunction

  function automatic kstep_t key_release(hkrb_pkg::kbd_t k, logic [7:0] code);
    kstep_t s;
    map_t   m;
    s = '{kbd: k, ok: 1'b0};
    m = map_code(code);
    if (m.ok) begin
      s.ok       = 1'b1;
      s.kbd.mods = k.mods & ~m.mods;
      if (m.usage != 8'd0) begin
        for (int i = 0; i < hkrb_pkg::KEY_SLOTS; i++) begin
          if (k.slots[i] == m.usage) s.kbd.slots[i] = 8'd0;
        end
      end
    end
    return s;
  endfunction

  function automatic hkrb_pkg::out_t make_result(hkrb_pkg::kbd_t k, logic [15:0] med,
                                                 logic media, logic acc, logic lnk,
                                                 logic last);
    hkrb_pkg::out_t                     r;
    logic [hkrb_pkg::OUT_SLOTS-1:0][7:0] s;
    s = '0;
    for (int i = 0; i < hkrb_pkg::SHOWN_SLOTS; i++) begin
      s[i] = k.slots[i];
    end
    r.report_kind   = media;
    r.modifier_bits = media ? 8'd0 : k.mods;
    if (media) s = '0;
    r.slot_a      = s[0];
    r.slot_b      = s[1];
    r.slot_c      = s[2];
    r.slot_d      = s[3];
    r.slot_e      = s[4];
    r.slot_f      = s[5];
    r.media_bits  = med;
    r.accepted    = acc;
    r.sent        = acc & lnk;
    r.last_of_run = last;
    return r;
  endfunction

  hkrb_pkg::kbd_t kbd_r, kbd_nxt;
  logic [15:0]    media_r, media_nxt;
  logic           link_r, link_nxt;

  hkrb_pkg::out_t q_r [4];
  logic [1:0]     wptr_r, wptr_nxt;
  logic [1:0]     rptr_r, rptr_nxt;
  logic [2:0]     cnt_r, cnt_nxt;

  logic           in_acc;
  logic           pop;
  logic [1:0]     push_n;
  hkrb_pkg::out_t res0, res1;
  kstep_t         press_s, rel_s, tc_rel_s;

  assign in_stall  = (cnt_r > 3'd2);
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid & ~out_stall;
  assign out_payload = q_r[rptr_r];

  always_comb begin
    press_s   = key_press(kbd_r, in_payload.key_code);
    rel_s     = key_release(kbd_r, in_payload.key_code);
    tc_rel_s  = key_release(press_s.kbd, in_payload.key_code);
    kbd_nxt   = kbd_r;
    media_nxt = media_r;
    link_nxt  = link_r;
    res0      = '0;
    res1      = '0;
    push_n    = 2'd0;
    if (in_acc) begin
      unique case (in_payload.op)
        hkrb_pkg::OP_PRESS: begin
          kbd_nxt = press_s.kbd;
          res0    = make_result(press_s.kbd, media_r, 1'b0, press_s.ok, link_r, 1'b1);
          push_n  = 2'd1;
        end
        hkrb_pkg::OP_RELEASE: begin
          kbd_nxt = rel_s.kbd;
          res0    = make_result(rel_s.kbd, media_r, 1'b0, rel_s.ok, link_r, 1'b1);
          push_n  = 2'd1;
        end
        hkrb_pkg::OP_MEDIA_PRESS: begin
          media_nxt = media_r | in_payload.media_mask;
          res0      = make_result(kbd_r, media_nxt, 1'b1, 1'b1, link_r, 1'b1);
          push_n    = 2'd1;
        end
        hkrb_pkg::OP_MEDIA_REL: begin
          media_nxt = media_r & ~in_payload.media_mask;
          res0      = make_result(kbd_r, media_nxt, 1'b1, 1'b1, link_r, 1'b1);
          push_n    = 2'd1;
        end
        hkrb_pkg::OP_RELEASE_ALL: begin
          kbd_nxt   = '0;
          media_nxt = 16'd0;
          res0      = make_result('0, 16'd0, 1'b0, 1'b1, link_r, 1'b0);
          res1      = make_result('0, 16'd0, 1'b1, 1'b1, link_r, 1'b1);
          push_n    = 2'd2;
        end
        hkrb_pkg::OP_LINK_UP: begin
          link_nxt = 1'b1;
        end
        hkrb_pkg::OP_LINK_DOWN: begin
          link_nxt = 1'b0;
        end
        hkrb_pkg::OP_TYPE_CHAR: begin
          kbd_nxt = tc_rel_s.kbd;
          res0    = make_result(press_s.kbd, media_r, 1'b0, press_s.ok, link_r, 1'b0);
          res1    = make_result(tc_rel_s.kbd, media_r, 1'b0, tc_rel_s.ok, link_r, 1'b1);
          push_n  = 2'd2;
        end
        default: begin
          push_n = 2'd0;
        end
      endcase
    end
    wptr_nxt = wptr_r + push_n;
    rptr_nxt = rptr_r + {1'b0, pop};
    cnt_nxt  = cnt_r + {1'b0, push_n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbd_r   <= '0;
      media_r <= 16'd0;
      link_r  <= 1'b0;
      wptr_r  <= 2'd0;
      rptr_r  <= 2'd0;
      cnt_r   <= 3'd0;
    end else begin
      kbd_r   <= kbd_nxt;
      media_r <= media_nxt;
      link_r  <= link_nxt;
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wptr_r] <= res0;
    if (push_n == 2'd2) q_r[wptr_r + 2'd1] <= res1;
  end

endmodule

// ===== rtl/hkrb_checker.sv =====
// port-level checks for the keyboard report builder, bound to the top level
// depends on hkrb_pkg and hid_keyboard_report_builder_assert.svh
`include "hid_keyboard_report_builder_assert.svh"

module hkrb_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input hkrb_pkg::in_t  in_payload,
  input logic           out_valid,
  input logic           out_stall,
  input hkrb_pkg::out_t out_payload
);

  `HKRB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `HKRB_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_payload))
  `HKRB_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid)
  `HKRB_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_payload))
  `HKRB_ASSERT_NOW(a_sent_needs_accept, out_valid && out_payload.sent, out_payload.accepted)

endmodule

bind hid_keyboard_report_builder hkrb_checker u_hkrb_checker (.*);

// ===== sim/hid_keyboard_report_builder_test.sv =====
// self-checking testbench for hid_keyboard_report_builder: directed and random key,
// media, link and release-all events checked against an in-bench report predictor
// depends on hkrb_pkg and the hid_keyboard_report_builder rtl
module hid_keyboard_report_builder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  hkrb_pkg::in_t  in_payload;
  logic           out_valid;
  logic           out_stall;
  hkrb_pkg::out_t out_payload;

  logic [7:0]  held_mods;
  logic [7:0]  held_keys [hkrb_pkg::KEY_SLOTS];
  logic [15:0] held_media;
  logic        link_is_up;

  hkrb_pkg::out_t pending_reports [$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  bit   idle_on = 1'b1;

  hid_keyboard_report_builder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload)
  );

  always #6 clk = ~clk;

  function automatic bit decode_key(input logic [7:0] code, output logic [7:0] usage,
                                    output logic [7:0] mods);
    logic [7:0] entry;
    usage = 8'h00;
    mods = 8'h00;
    if (code >= hkrb_pkg::RAW_BASE) begin
      usage = code - hkrb_pkg::RAW_BASE;
    end else if (code[7]) begin
      mods = 8'h01 << code[2:0];
    end else begin
      entry = hkrb_pkg::ASCII_USAGE[code[6:0]];
      if (entry == 8'h00) return 1'b0;
      usage = {1'b0, entry[6:0]};
      mods = entry[7] ? hkrb_pkg::LEFT_SHIFT : 8'h00;
    end
    return 1'b1;
  endfunction

  function automatic bit press_key(input logic [7:0] code);
    logic [7:0] usage;
    logic [7:0] mods;
    if (!decode_key(code, usage, mods)) return 1'b0;
    held_mods |= mods;
    foreach (held_keys[i]) if (held_keys[i] == usage) return 1'b1;
    foreach (held_keys[i]) begin
      if (held_keys[i] == 8'h00) begin
        held_keys[i] = usage;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit release_key(input logic [7:0] code);
    logic [7:0] usage;
    logic [7:0] mods;
    if (!decode_key(code, usage, mods)) return 1'b0;
    held_mods &= ~mods;
    if (usage != 8'h00) begin
      foreach (held_keys[i]) if (held_keys[i] == usage) held_keys[i] = 8'h00;
    end
    return 1'b1;
  endfunction

  function automatic hkrb_pkg::out_t build_report(input bit media, input bit ok,
                                                  input bit last);
    hkrb_pkg::out_t r;
    r = '0;
    r.report_kind = media;
    if (!media) begin
      r.modifier_bits = held_mods;
      r.slot_a = held_keys[0];
      r.slot_b = held_keys[1];
      r.slot_c = held_keys[2];
      r.slot_d = held_keys[3];
      r.slot_e = held_keys[4];
      r.slot_f = held_keys[5];
    end
    r.media_bits = held_media;
    r.accepted = ok;
    r.sent = ok && link_is_up;
    r.last_of_run = last;
    return r;
  endfunction

  function automatic void predict_reports(input hkrb_pkg::in_t ev);
    bit ok;
    case (ev.op)
      hkrb_pkg::OP_PRESS: begin
        ok = press_key(ev.key_code);
        pending_reports.push_back(build_report(1'b0, ok, 1'b1));
      end
      hkrb_pkg::OP_RELEASE: begin
        ok = release_key(ev.key_code);
        pending_reports.push_back(build_report(1'b0, ok, 1'b1));
      end
      hkrb_pkg::OP_MEDIA_PRESS: begin
        held_media |= ev.media_mask;
        pending_reports.push_back(build_report(1'b1, 1'b1, 1'b1));
      end
      hkrb_pkg::OP_MEDIA_REL: begin
        held_media &= ~ev.media_mask;
        pending_reports.push_back(build_report(1'b1, 1'b1, 1'b1));
      end
      hkrb_pkg::OP_RELEASE_ALL: begin
        held_mods = 8'h00;
        foreach (held_keys[i]) held_keys[i] = 8'h00;
        held_media = 16'h0000;
        pending_reports.push_back(build_report(1'b0, 1'b1, 1'b0));
        pending_reports.push_back(build_report(1'b1, 1'b1, 1'b1));
      end
      hkrb_pkg::OP_LINK_UP: link_is_up = 1'b1;
      hkrb_pkg::OP_LINK_DOWN: link_is_up = 1'b0;
      default: begin
        ok = press_key(ev.key_code);
        pending_reports.push_back(build_report(1'b0, ok, 1'b0));
        ok = release_key(ev.key_code);
        pending_reports.push_back(build_report(1'b0, ok, 1'b1));
      end
    endcase
  endfunction

  task automatic send_event(input hkrb_pkg::op_t op, input logic [7:0] code,
                            input logic [15:0] mask);
    hkrb_pkg::in_t ev;
    ev.op = op;
    ev.key_code = code;
    ev.media_mask = mask;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_payload = ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_reports(ev);
  endtask

  task automatic report_mismatch(input string what, input hkrb_pkg::out_t want,
                                 input hkrb_pkg::out_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $write("%0t %s: expected kind %0d mods %h slots %h %h %h %h %h %h", $realtime, what,
             want.report_kind, want.modifier_bits, want.slot_a, want.slot_b, want.slot_c,
             want.slot_d, want.slot_e, want.slot_f);
      $display(" media %h acc %0d sent %0d last %0d", want.media_bits, want.accepted,
               want.sent, want.last_of_run);
      $write("%0t %s:   actual kind %0d mods %h slots %h %h %h %h %h %h", $realtime, what,
             got.report_kind, got.modifier_bits, got.slot_a, got.slot_b, got.slot_c,
             got.slot_d, got.slot_e, got.slot_f);
      $display(" media %h acc %0d sent %0d last %0d", got.media_bits, got.accepted,
               got.sent, got.last_of_run);
    end
  endtask

  // one result transaction per accepted edge
  always @(posedge clk) begin
    hkrb_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected report", '0, out_payload);
      end else begin
        want = pending_reports.pop_front();
        if (out_payload.report_kind !== want.report_kind
            || out_payload.modifier_bits !== want.modifier_bits
            || out_payload.slot_a !== want.slot_a || out_payload.slot_b !== want.slot_b
            || out_payload.slot_c !== want.slot_c || out_payload.slot_d !== want.slot_d
            || out_payload.slot_e !== want.slot_e || out_payload.slot_f !== want.slot_f
            || out_payload.media_bits !== want.media_bits
            || out_payload.accepted !== want.accepted || out_payload.sent !== want.sent
            || out_payload.last_of_run !== want.last_of_run) begin
          report_mismatch("report mismatch", want, out_payload);
        end
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL hid_keyboard_report_builder");
    $finish;
  end

  function automatic logic [7:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 8'h61 + 8'($urandom_range(0, 9));
    if (roll < 60) return 8'h41 + 8'($urandom_range(0, 9));
    if (roll < 72) return 8'd128 + 8'($urandom_range(0, 7));
    if (roll < 85) return hkrb_pkg::RAW_BASE + 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_key_mapping();
    send_event(hkrb_pkg::OP_PRESS, 8'h61, 16'h0000);
    send_event(hkrb_pkg::OP_LINK_UP, 8'h00, 16'h0000);
    send_event(hkrb_pkg::OP_PRESS, 8'h41, 16'h0000);
    send_event(hkrb_pkg::OP_PRESS, 8'd128, 16'h0000);
    send_event(hkrb_pkg::OP_PRESS, 8'd135, 16'hFFFF);
    send_event(hkrb_pkg::OP_PRESS, 8'd255, 16'h0000);
    send_event(hkrb_pkg::OP_PRESS, hkrb_pkg::RAW_BASE, 16'h0000);
    send_event(hkrb_pkg::OP_RELEASE, 8'h61, 16'h0000);
    send_event(hkrb_pkg::OP_RELEASE, 8'h41, 16'h0000);
    send_event(hkrb_pkg::OP_PRESS, 8'h00, 16'hFFFF);
  endtask

  task automatic test_slot_overflow();
    send_event(hkrb_pkg::OP_RELEASE_ALL, 8'h00, 16'h0000);
    for (int k = 0; k < hkrb_pkg::KEY_SLOTS; k++) begin
      send_event(hkrb_pkg::OP_PRESS, 8'h31 + 8'(k), 16'h0000);
    end
    send_event(hkrb_pkg::OP_PRESS, 8'h37, 16'h0000);
    send_event(hkrb_pkg::OP_PRESS, 8'd130, 16'h0000);
    send_event(hkrb_pkg::OP_PRESS, 8'h33, 16'h0000);
    send_event(hkrb_pkg::OP_RELEASE, 8'h31, 16'h0000);
    send_event(hkrb_pkg::OP_PRESS, 8'h37, 16'h0000);
  endtask

  task automatic test_media_keys();
    send_event(hkrb_pkg::OP_MEDIA_PRESS, 8'hFF, 16'hFFFF);
    send_event(hkrb_pkg::OP_MEDIA_REL, 8'h00, 16'h00FF);
    send_event(hkrb_pkg::OP_LINK_DOWN, 8'h00, 16'h0000);
    send_event(hkrb_pkg::OP_RELEASE_ALL, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_type_char();
    send_event(hkrb_pkg::OP_LINK_UP, 8'h00, 16'h0000);
    send_event(hkrb_pkg::OP_TYPE_CHAR, 8'h0A, 16'h0000);
    send_event(hkrb_pkg::OP_TYPE_CHAR, 8'h7F, 16'h0000);
    send_event(hkrb_pkg::OP_TYPE_CHAR, 8'h5A, 16'h0000);
  endtask

  task automatic test_random_events(input int count);
    int unsigned   roll;
    hkrb_pkg::op_t op;
    logic [7:0]    code;
    repeat (count) begin
      code = pick_key();
      roll = $urandom_range(0, 99);
      if (roll < 38) op = hkrb_pkg::OP_PRESS;
      else if (roll < 58) op = hkrb_pkg::OP_RELEASE;
      else if (roll < 68) op = hkrb_pkg::OP_TYPE_CHAR;
      else if (roll < 74) op = hkrb_pkg::OP_MEDIA_PRESS;
      else if (roll < 80) op = hkrb_pkg::OP_MEDIA_REL;
      else if (roll < 83) op = hkrb_pkg::OP_RELEASE_ALL;
      else if (roll < 86) op = hkrb_pkg::OP_LINK_UP;
      else if (roll < 88) op = hkrb_pkg::OP_LINK_DOWN;
      else begin
        op = hkrb_pkg::op_t'($urandom_range(0, 7));
        code = 8'($urandom_range(0, 255));
      end
      send_event(op, code, 16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_events(150);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_payload = '0;
    held_mods = 8'h00;
    foreach (held_keys[i]) held_keys[i] = 8'h00;
    held_media = 16'h0000;
    link_is_up = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_key_mapping();
    test_slot_overflow();
    test_media_keys();
    test_type_char();
    test_random_events(900);
    test_back_to_back();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS hid_keyboard_report_builder");
    end else begin
      $display("FAIL hid_keyboard_report_builder");
    end
    $finish;
  end

endmodule
